FILE: hw/rtl/piq_pkg.sv
`timescale 1ns / 1ps

package piq_pkg;

  // list depth
  localparam int unsigned CAPACITY = 16;

  // field widths
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned CNTF_W   = 5;
  localparam int unsigned STATUS_W = 2;

  // internal count and slot widths
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned SLOT_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // what one cell does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_FROM_LEFT  = 2'd2,
    CELL_FROM_RIGHT = 2'd3
  } cell_op_e;

endpackage

FILE: hw/rtl/piq_in_if.sv
`timescale 1ns / 1ps

interface piq_in_if;
  import piq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic signed [DATA_W-1:0] value;
  logic [POS_W-1:0]         position;

  modport source (output valid, output kind, output value, output position, input ready);
  modport sink   (input valid, input kind, input value, input position, output ready);
endinterface

FILE: hw/rtl/piq_out_if.sv
`timescale 1ns / 1ps

interface piq_out_if;
  import piq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] removed_value;
  logic [STATUS_W-1:0]      status;
  logic [CNTF_W-1:0]        count;
  logic                     is_full;
  logic                     is_empty;

  modport source (output valid, output removed_value, output status, output count,
                  output is_full, output is_empty, input ready);
  modport sink   (input valid, input removed_value, input status, input count,
                  input is_full, input is_empty, output ready);
endinterface

FILE: hw/rtl/positional_insert_queue_core.sv
`timescale 1ns / 1ps
// channel | dir | fields                                          | handshake
// in_i    | in  | kind, value, position                           | valid/ready
// out_o   | out | removed_value, status, count, is_full, is_empty | valid/ready
//
// one word per cycle unless out_o stalls: every cell of the chain shifts or
// loads in the same cycle, so an insert or remove finishes when accepted.
// the result sits in an output register in the cycle after acceptance.
// reset clears the count and the output valid; cell contents are not reset.
// in_i.ready is high while the output register is empty or being taken.

module positional_insert_queue_core (
  input  logic clk_i,
  input  logic rst_ni,
  piq_in_if.sink    in_i,
  piq_out_if.source out_o
);
  import piq_pkg::*;

  logic [CAPACITY-1:0][DATA_W-1:0] cell_data;
  cell_op_e [CAPACITY-1:0]         cell_op;

  logic [CNT_W-1:0]  count_d, count_q;
  logic              accept;
  logic              is_insert;
  logic              list_full, list_empty;
  logic [SLOT_W-1:0] pos_ext, cnt_ext, slot_raw, slot_clamp;
  logic [CNT_W-1:0]  slot;
  logic              do_insert, do_remove;
  status_e           status;
  logic [DATA_W-1:0] removed;
  logic [SLOT_W-1:0] cnt_next_ext;

  logic                     out_valid_q;
  logic [DATA_W-1:0]        removed_q;
  status_e                  status_q;
  logic [CNTF_W-1:0]        count_out_q;
  logic                     is_full_q, is_empty_q;

  // handshake
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign is_insert  = (in_i.kind == KIND_INSERT);

  assign list_full  = (count_q == CNT_W'(CAPACITY));
  assign list_empty = (count_q == '0);

  // target slot: low positions land after the front, far ones append
  assign pos_ext    = SLOT_W'(in_i.position);
  assign cnt_ext    = SLOT_W'(count_q);
  assign slot_raw   = (pos_ext <= SLOT_W'(2)) ? SLOT_W'(1) : pos_ext - SLOT_W'(1);
  assign slot_clamp = (slot_raw > cnt_ext) ? cnt_ext : slot_raw;
  assign slot       = list_empty ? '0 : slot_clamp[CNT_W-1:0];

  assign do_insert = accept && is_insert && !list_full;
  assign do_remove = accept && !is_insert && !list_empty;

  // status, removed word and next count
  always_comb begin
    status  = ST_DONE;
    removed = '0;
    count_d = count_q;
    if (is_insert) begin
      if (list_full) begin
        status = ST_FULL;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end else begin
      if (list_empty) begin
        status = ST_EMPTY;
      end else begin
        removed = cell_data[0];
        count_d = count_q - CNT_W'(1);
      end
    end
  end

  assign cnt_next_ext = SLOT_W'(count_d);

  // per-cell shift control
  for (genvar i = 0; i < CAPACITY; i++) begin : g_op
    localparam logic [CNT_W-1:0] Idx = CNT_W'(i);
    always_comb begin
      if (do_remove) begin
        cell_op[i] = CELL_FROM_RIGHT;
      end else if (do_insert) begin
        if (Idx == slot) begin
          cell_op[i] = CELL_LOAD;
        end else if (Idx > slot) begin
          cell_op[i] = CELL_FROM_LEFT;
        end else begin
          cell_op[i] = CELL_HOLD;
        end
      end else begin
        cell_op[i] = CELL_HOLD;
      end
    end
  end

  // chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = in_i.value;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    piq_cell u_cell (
      .clk_i  (clk_i),
      .op_i   (cell_op[i]),
      .load_i (in_i.value),
      .left_i (left),
      .right_i(right),
      .data_o (cell_data[i])
    );
  end

  // fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      removed_q   <= removed;
      status_q    <= status;
      count_out_q <= cnt_next_ext[CNTF_W-1:0];
      is_full_q   <= (count_d == CNT_W'(CAPACITY));
      is_empty_q  <= (count_d == '0);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.removed_value = removed_q;
  assign out_o.status        = status_q;
  assign out_o.count         = count_out_q;
  assign out_o.is_full       = is_full_q;
  assign out_o.is_empty      = is_empty_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_insert |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_remove_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_remove |=> out_o.removed_value == $past(cell_data[0]) && out_o.status == ST_DONE)
    else $error("remove did not return the front word");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(is_full_q && is_empty_q))
    else $error("full and empty both set");

endmodule

FILE: hw/rtl/piq_cell.sv
`timescale 1ns / 1ps

module piq_cell (
  input  logic                      clk_i,
  input  piq_pkg::cell_op_e         op_i,
  input  logic [piq_pkg::DATA_W-1:0] load_i,
  input  logic [piq_pkg::DATA_W-1:0] left_i,
  input  logic [piq_pkg::DATA_W-1:0] right_i,
  output logic [piq_pkg::DATA_W-1:0] data_o
);
  import piq_pkg::*;

  logic [DATA_W-1:0] data_d, data_q;

  // pick new word for this place in the list
  always_comb begin
    case (op_i)
      CELL_LOAD:       data_d = load_i;
      CELL_FROM_LEFT:  data_d = left_i;
      CELL_FROM_RIGHT: data_d = right_i;
      default:         data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

FILE: tb/positional_insert_queue_core_tb.sv
`timescale 1ns / 1ps

module positional_insert_queue_core_tb;
  import piq_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh80000000;

  typedef struct {
    logic signed [DATA_W-1:0] removed_value;
    status_e                  status;
    logic [CNTF_W-1:0]        count;
    logic                     is_full;
    logic                     is_empty;
  } list_result_t;

  logic clk_i;
  logic rst_ni;

  piq_in_if  in_bus ();
  piq_out_if out_bus ();

  positional_insert_queue_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus.sink),
    .out_o  (out_bus.source)
  );

  // mirror of the list contents
  logic signed [DATA_W-1:0] held_words [CAPACITY];
  int                       held_count;

  list_result_t pending_results [$];
  int           mismatch_count;
  int           cycle_count;
  bit           idle_on;
  int           hold_request;
  int           hold_left;

  // clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // apply one insert or remove to the mirror and return the word it yields
  function automatic list_result_t predict_list_op(input kind_e kind,
                                                   input logic signed [DATA_W-1:0] value,
                                                   input logic [POS_W-1:0] position);
    list_result_t r;
    int slot;
    r.removed_value = '0;
    r.status        = ST_DONE;
    if (kind == KIND_REMOVE) begin
      if (held_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.removed_value = held_words[0];
        for (int k = 0; k < held_count - 1; k++) held_words[k] = held_words[k+1];
        held_count--;
      end
    end else if (held_count >= CAPACITY) begin
      r.status = ST_FULL;
    end else if (held_count == 0) begin
      held_words[0] = value;
      held_count = 1;
    end else begin
      // low positions land right after the front, far ones append
      slot = (position <= 2) ? 1 : int'(position) - 1;
      if (slot > held_count) slot = held_count;
      for (int k = held_count; k > slot; k--) held_words[k] = held_words[k-1];
      held_words[slot] = value;
      held_count++;
    end
    r.count    = held_count[CNTF_W-1:0];
    r.is_full  = (held_count == CAPACITY);
    r.is_empty = (held_count == 0);
    return r;
  endfunction

  // offer one word and wait for it to be taken
  task automatic send_word(input kind_e kind, input logic signed [DATA_W-1:0] value,
                           input logic [POS_W-1:0] position);
    if (idle_on) begin
      while ($urandom_range(99) < 29) begin
        in_bus.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_bus.valid    <= 1'b1;
    in_bus.kind     <= kind;
    in_bus.value    <= value;
    in_bus.position <= position;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    pending_results.push_back(predict_list_op(kind, value, position));
  endtask

  // random word, values biased toward extremes, positions toward the live range
  task automatic send_random(input int insert_pct);
    kind_e                    kind;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
    kind = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
    case ($urandom_range(7))
      0:       value = WORD_MAX;
      1:       value = WORD_MIN;
      2:       value = '0;
      3:       value = -1;
      default: value = $urandom;
    endcase
    if ($urandom_range(1) == 0) position = 5'($urandom_range(31));
    else position = (held_count + 2 > 31) ? 5'd31 : 5'($urandom_range(held_count + 2));
    send_word(kind, value, position);
  endtask

  task automatic compare_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_result();
    list_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result word, expected none, actual status %0d count %0d",
               $time, out_bus.status, out_bus.count);
      mismatch_count++;
    end else begin
      want = pending_results.pop_front();
      compare_field("removed_value", want.removed_value, out_bus.removed_value);
      compare_field("status", want.status, out_bus.status);
      compare_field("count", want.count, out_bus.count);
      compare_field("is_full", want.is_full, out_bus.is_full);
      compare_field("is_empty", want.is_empty, out_bus.is_empty);
    end
  endtask

  // result side: check taken words, then pick ready for the next edge
  initial begin
    out_bus.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_bus.valid && out_bus.ready) check_result();
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= idle_on ? ($urandom_range(99) >= 29) : 1'b1;
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic wait_for_drain();
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // empty reject, low and far positions, word extremes, fill to full, full reject
  task automatic test_reject_and_extremes();
    send_word(KIND_REMOVE, $urandom, 5'($urandom_range(31)));
    send_word(KIND_INSERT, WORD_MAX, 5'd0);
    send_word(KIND_INSERT, WORD_MIN, 5'd0);
    send_word(KIND_INSERT, -1, 5'd1);
    send_word(KIND_INSERT, '0, 5'd2);
    send_word(KIND_INSERT, 32'sh55555555, 5'd31);
    send_word(KIND_INSERT, 32'shaaaaaaaa, 5'd16);
    send_word(KIND_INSERT, 1, 5'd3);
    for (int k = 0; k < 9; k++) send_word(KIND_INSERT, $urandom, 5'(4 + k));
    send_word(KIND_INSERT, $urandom, 5'd5);
    repeat (3) send_word(KIND_REMOVE, $urandom, 5'($urandom_range(31)));
    send_word(KIND_INSERT, $urandom, 5'd14);
    send_word(KIND_INSERT, $urandom, 5'd15);
    send_word(KIND_REMOVE, '0, '0);
  endtask

  // phases of insert-heavy and remove-heavy traffic sweep the list empty to full
  task automatic test_random_traffic(input int n_words);
    int insert_pct;
    insert_pct = 55;
    for (int i = 0; i < n_words; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(4))
          0:       insert_pct = 95;
          1:       insert_pct = 80;
          2:       insert_pct = 25;
          3:       insert_pct = 8;
          default: insert_pct = 55;
        endcase
      end
      send_random(insert_pct);
    end
  endtask

  // back to back words on both sides
  task automatic test_unthrottled();
    idle_on = 1'b0;
    test_random_traffic(100);
    idle_on = 1'b1;
  endtask

  // result side holds off while words keep coming, so the input stalls
  task automatic test_output_backpressure();
    hold_request = 150;
    for (int i = 0; i < 40; i++) send_random(60);
  endtask

  // sender pauses until every result is back, then resumes
  task automatic test_drain_pause();
    for (int i = 0; i < 40; i++) send_random(70);
    wait_for_drain();
    for (int i = 0; i < 40; i++) send_random(40);
  endtask

  initial begin
    rst_ni          <= 1'b0;
    in_bus.valid    <= 1'b0;
    in_bus.kind     <= KIND_INSERT;
    in_bus.value    <= '0;
    in_bus.position <= '0;
    held_count     = 0;
    mismatch_count = 0;
    hold_request   = 0;
    idle_on        = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reject_and_extremes();
    test_random_traffic(200);
    test_unthrottled();
    test_output_backpressure();
    test_drain_pause();

    wait_for_drain();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: positional_insert_queue_core.f
hw/rtl/piq_pkg.sv
hw/rtl/piq_in_if.sv
hw/rtl/piq_out_if.sv
hw/rtl/piq_cell.sv
hw/rtl/positional_insert_queue_core.sv
tb/positional_insert_queue_core_tb.sv
